### hw/rtl/rainbow_hue_color_generator_assert.svh
// ----------------------------------------------------------------------------
// rainbow hue color generator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RAINBOW_HUE_COLOR_GENERATOR_ASSERT_SVH
`define RAINBOW_HUE_COLOR_GENERATOR_ASSERT_SVH

// same-cycle implication
`define RHCG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rhcg assertion failed");

// next-cycle implication
`define RHCG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rhcg assertion failed");

`endif

### hw/rtl/rhcg_pkg.sv
// ----------------------------------------------------------------------------
// rhcg_pkg
// types, constants and helpers of the rainbow hue color generator
// ----------------------------------------------------------------------------
package rhcg_pkg;

	localparam int HueW   = 11;
	localparam int ChanW  = 8;
	localparam int StepW  = 11;
	localparam int CfgW   = 11;
	localparam int ProdW  = 16;
	localparam int TriW   = 9;

	// hue ring: six sectors of 256
	localparam logic [HueW:0] HueRing = 12'd1536;
	localparam logic [9:0]    TriPeriod = 10'd512;

	typedef enum logic [1:0] {
		REG_HUE_STEP   = 2'd0,
		REG_SATURATION = 2'd1,
		REG_BRIGHTNESS = 2'd2
	} rhcg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHROMA,
		ST_SCALE,
		ST_SECOND,
		ST_MIX
	} rhcg_state_t;

	typedef struct packed {
		logic idle;
		logic done;
	} rhcg_status_t;

	// floor(x / 255) for x up to 65025, by reciprocal with correction
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] s;
		s = {1'b0, x} + 17'd1 + {9'd0, x[ProdW-1:8]};
		return s[15:8];
	endfunction

endpackage

### hw/rtl/rhcg_if.sv
// ----------------------------------------------------------------------------
// rhcg channel interfaces
// valid/ready channels for tick words and color words
// ----------------------------------------------------------------------------
interface rhcg_tick_if;
	logic valid;
	logic ready;
	logic advance;

	modport source (output valid, output advance, input ready);
	modport sink (input valid, input advance, output ready);
endinterface

interface rhcg_color_if;
	logic                          valid;
	logic                          ready;
	logic [rhcg_pkg::ChanW-1:0]    red;
	logic [rhcg_pkg::ChanW-1:0]    green;
	logic [rhcg_pkg::ChanW-1:0]    blue;
	logic [rhcg_pkg::HueW-1:0]     hue_out;

	modport source (output valid, output red, output green, output blue, output hue_out,
		input ready);
	modport sink (input valid, input red, input green, input blue, input hue_out,
		output ready);
endinterface

### hw/rtl/rhcg_core.sv
// ----------------------------------------------------------------------------
// rhcg_core
// sequenced hsv to rgb conversion around one shared 9x8 multiplier
// ----------------------------------------------------------------------------
module rhcg_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rhcg_pkg::HueW-1:0]   hue,
	input  logic [rhcg_pkg::ChanW-1:0]  sat,
	input  logic [rhcg_pkg::ChanW-1:0]  val,
	input  logic                        out_free,
	output rhcg_pkg::rhcg_status_t      status,
	output logic [rhcg_pkg::ChanW-1:0]  red,
	output logic [rhcg_pkg::ChanW-1:0]  green,
	output logic [rhcg_pkg::ChanW-1:0]  blue
);

	rhcg_pkg::rhcg_state_t state_q, state_nxt;

	logic [rhcg_pkg::HueW-1:0]  hue_q;
	logic [rhcg_pkg::ChanW-1:0] chroma_q;
	logic [rhcg_pkg::ProdW-1:0] prod_q;

	logic [rhcg_pkg::TriW-1:0]  tri_val;
	logic [9:0]                 tri_diff;
	logic [rhcg_pkg::TriW-1:0]  mul_a;
	logic [rhcg_pkg::ChanW-1:0] mul_b;
	logic [16:0]                mul_p;
	logic                       sel_chroma;
	logic [rhcg_pkg::ChanW-1:0] second;
	logic [rhcg_pkg::ChanW-1:0] base;
	logic [rhcg_pkg::ChanW-1:0] r_raw, g_raw, b_raw;

	// triangle of hue mod 512, peak 256
	assign tri_diff = rhcg_pkg::TriPeriod - {1'b0, hue_q[8:0]};
	assign tri_val  = hue_q[8] ? tri_diff[8:0] : {1'b0, hue_q[7:0]};

	// shared multiplier
	assign mul_a = sel_chroma ? {1'b0, sat} : tri_val;
	assign mul_b = sel_chroma ? val : chroma_q;
	assign mul_p = {8'd0, mul_a} * {9'd0, mul_b};

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rhcg_pkg::ST_IDLE:   if (start) state_nxt = rhcg_pkg::ST_CHROMA;
			rhcg_pkg::ST_CHROMA: state_nxt = rhcg_pkg::ST_SCALE;
			rhcg_pkg::ST_SCALE:  state_nxt = rhcg_pkg::ST_SECOND;
			rhcg_pkg::ST_SECOND: state_nxt = rhcg_pkg::ST_MIX;
			rhcg_pkg::ST_MIX:    if (out_free) state_nxt = rhcg_pkg::ST_IDLE;
			default:             state_nxt = rhcg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sel_chroma  = 1'b0;
		status.idle = 1'b0;
		status.done = 1'b0;
		case (state_q)
			rhcg_pkg::ST_IDLE:   status.idle = 1'b1;
			rhcg_pkg::ST_CHROMA: sel_chroma = 1'b1;
			rhcg_pkg::ST_MIX:    status.done = out_free;
			default:             sel_chroma = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhcg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rhcg_pkg::ST_IDLE && start) hue_q <= hue;
		if (state_q == rhcg_pkg::ST_CHROMA || state_q == rhcg_pkg::ST_SECOND)
			prod_q <= mul_p[rhcg_pkg::ProdW-1:0];
		if (state_q == rhcg_pkg::ST_SCALE) chroma_q <= rhcg_pkg::div255(prod_q);
	end

	// secondary = tri * chroma / 256
	assign second = prod_q[15:8];
	assign base   = val - chroma_q;

	always_comb begin
		case (hue_q[10:8])
			3'd0:    begin r_raw = chroma_q; g_raw = second;   b_raw = '0;       end
			3'd1:    begin r_raw = second;   g_raw = chroma_q; b_raw = '0;       end
			3'd2:    begin r_raw = '0;       g_raw = chroma_q; b_raw = second;   end
			3'd3:    begin r_raw = '0;       g_raw = second;   b_raw = chroma_q; end
			3'd4:    begin r_raw = second;   g_raw = '0;       b_raw = chroma_q; end
			default: begin r_raw = chroma_q; g_raw = '0;       b_raw = second;   end
		endcase
	end

	assign red   = r_raw + base;
	assign green = g_raw + base;
	assign blue  = b_raw + base;

endmodule

### hw/rtl/rainbow_hue_color_generator.sv
// ----------------------------------------------------------------------------
// rainbow_hue_color_generator
// hue ring walker with hsv to rgb conversion of each tick
// ----------------------------------------------------------------------------
// Each tick word returns one color word: the current hue position (0..1535,
// six sectors of 256) converted to RGB with the configured saturation and
// brightness, plus the hue used. When advance is set the hue then moves on by
// hue_step, modulo 1536. A tick passes from acceptance through the chroma
// product, the divide by 255, the secondary product and the channel mix,
// where the color word is loaded, and the sequencer then returns to idle
// before it takes the next tick, so no tick is taken while the previous
// one is still in conversion: the two products share one 9x8 multiplier.
// The mix state is held for as long as the output register holds a word
// that is not being taken. A new tick is taken once the sequencer is back
// in idle, even while the previous color word still sits in the output
// register. Configuration is a plain write port; index 3 is ignored.
// ----------------------------------------------------------------------------
`include "rainbow_hue_color_generator_assert.svh"

module rainbow_hue_color_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [rhcg_pkg::CfgW-1:0]  cfg_data,
	rhcg_tick_if.sink                  tick,
	rhcg_color_if.source               color
);

	// configuration registers
	logic [rhcg_pkg::StepW-1:0] step_q;
	logic [rhcg_pkg::ChanW-1:0] sat_q;
	logic [rhcg_pkg::ChanW-1:0] bright_q;

	// hue ring position, always below 1536
	logic [rhcg_pkg::HueW-1:0]  hue_pos_q;

	// output register
	logic                       out_valid_q;
	logic [rhcg_pkg::ChanW-1:0] red_q, green_q, blue_q;
	logic [rhcg_pkg::HueW-1:0]  hue_out_q;
	logic [rhcg_pkg::HueW-1:0]  hue_cur_q;

	rhcg_pkg::rhcg_status_t     status;
	logic                       accept;
	logic                       out_free;
	logic [rhcg_pkg::ChanW-1:0] red_c, green_c, blue_c;

	logic [rhcg_pkg::HueW-1:0]  step_eff;
	logic [rhcg_pkg::HueW:0]    hue_sum;
	logic [rhcg_pkg::HueW:0]    hue_wrap;

	assign accept   = tick.valid && tick.ready;
	assign tick.ready = status.idle;

	// slot frees when empty or being drained this cycle
	assign out_free = !out_valid_q || color.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= 11'd19;
			sat_q    <= 8'd255;
			bright_q <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_idx)
				rhcg_pkg::REG_HUE_STEP:   step_q   <= cfg_data;
				rhcg_pkg::REG_SATURATION: sat_q    <= cfg_data[rhcg_pkg::ChanW-1:0];
				rhcg_pkg::REG_BRIGHTNESS: bright_q <= cfg_data[rhcg_pkg::ChanW-1:0];
				default:                  step_q   <= step_q;
			endcase
		end
	end

	// a step of 1536 or more acts as step - 1536, so the sum stays below 3072
	always_comb begin
		if ({1'b0, step_q} >= rhcg_pkg::HueRing)
			step_eff = step_q - rhcg_pkg::HueRing[rhcg_pkg::HueW-1:0];
		else
			step_eff = step_q;
		hue_sum = {1'b0, hue_pos_q} + {1'b0, step_eff};
		if (hue_sum >= rhcg_pkg::HueRing)
			hue_wrap = hue_sum - rhcg_pkg::HueRing;
		else
			hue_wrap = hue_sum;
	end

	// hue moves on at acceptance; the word keeps the old hue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_pos_q <= '0;
		end else if (accept && tick.advance) begin
			hue_pos_q <= hue_wrap[rhcg_pkg::HueW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) hue_cur_q <= hue_pos_q;
	end

	rhcg_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.hue      (hue_pos_q),
		.sat      (sat_q),
		.val      (bright_q),
		.out_free (out_free),
		.status   (status),
		.red      (red_c),
		.green    (green_c),
		.blue     (blue_c)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.done) begin
			out_valid_q <= 1'b1;
		end else if (color.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			red_q     <= red_c;
			green_q   <= green_c;
			blue_q    <= blue_c;
			hue_out_q <= hue_cur_q;
		end
	end

	assign color.valid   = out_valid_q;
	assign color.red     = red_q;
	assign color.green   = green_q;
	assign color.blue    = blue_q;
	assign color.hue_out = hue_out_q;

	// hue position stays on the ring
	`RHCG_ASSERT_NOW(a_hue_on_ring, 1'b1, ({1'b0, hue_pos_q} < rhcg_pkg::HueRing))
	// sequencer is busy right after taking a tick
	`RHCG_ASSERT_NEXT(a_busy_after_accept, accept, !tick.ready)
	// a finished conversion always shows up as a valid word
	`RHCG_ASSERT_NEXT(a_done_to_valid, status.done, color.valid)

endmodule

### tb/sv/rainbow_hue_color_generator_tb.sv
// ----------------------------------------------------------------------------
// rainbow_hue_color_generator_tb
// self-checking bench: a directed table of ticks and register writes, then
// random tick words over several register settings, each color word compared
// field by field against a typed-in color or an in-bench hsv to rgb predictor
// ----------------------------------------------------------------------------
module rainbow_hue_color_generator_tb;

	// arithmetic constants of the conversion
	localparam int FullScale  = 255;
	localparam int SectorSize = 256;
	localparam int RampPeriod = int'(rhcg_pkg::TriPeriod);
	localparam int RingSize   = int'(rhcg_pkg::HueRing);

	// register indexes, the spare one is ignored by the block
	localparam logic [1:0] IdxStep   = rhcg_pkg::REG_HUE_STEP;
	localparam logic [1:0] IdxSat    = rhcg_pkg::REG_SATURATION;
	localparam logic [1:0] IdxBright = rhcg_pkg::REG_BRIGHTNESS;
	localparam logic [1:0] IdxSpare  = 2'd3;

	localparam int IdlePct     = 21;
	localparam int PhaseCount  = 10;
	localparam int PhaseWords  = 105;
	localparam int DrainCycles = 20;
	localparam int TimeLimit   = 2000000;

	typedef struct packed {
		logic [rhcg_pkg::ChanW-1:0] red;
		logic [rhcg_pkg::ChanW-1:0] green;
		logic [rhcg_pkg::ChanW-1:0] blue;
		logic [rhcg_pkg::HueW-1:0]  hue;
	} color_word_t;

	typedef enum logic {
		ROW_TICK,
		ROW_WRITE
	} row_kind_t;

	// one line of the directed table: a tick word or a register write
	typedef struct packed {
		row_kind_t                 kind;
		logic                      advance;
		logic [1:0]                idx;
		logic [rhcg_pkg::CfgW-1:0] data;
		logic                      typed;
		color_word_t               known_color;
	} stim_row_t;

	localparam int RowCount = 24;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [1:0]                cfg_idx;
	logic [rhcg_pkg::CfgW-1:0] cfg_data;

	rhcg_tick_if  tick_ch ();
	rhcg_color_if color_ch ();

	rainbow_hue_color_generator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.tick     (tick_ch),
		.color    (color_ch)
	);

	// predictor copy of the block's registers and hue ring position
	logic [rhcg_pkg::StepW-1:0] step_cfg;
	logic [rhcg_pkg::ChanW-1:0] sat_cfg;
	logic [rhcg_pkg::ChanW-1:0] bright_cfg;
	logic [rhcg_pkg::HueW-1:0]  hue_now;

	// colors still owed by the block, oldest first
	color_word_t expected_colors[$];
	int          color_errors = 0;

	// a directed row may carry its color typed in, used instead of the predictor
	logic        use_known = 1'b0;
	color_word_t known_color;

	// no idling on either side while this is set
	logic calm_stretch = 1'b0;

	stim_row_t directed_rows[RowCount];

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hsv to rgb of one hue position at the given saturation and value
	function automatic color_word_t predict_color(input logic [rhcg_pkg::HueW-1:0] hue,
		input logic [rhcg_pkg::ChanW-1:0] sat, input logic [rhcg_pkg::ChanW-1:0] val);
		int unsigned h, s, v;
		int unsigned chroma, ramp, second, base;
		int unsigned r, g, b;
		color_word_t c;
		h = hue;
		s = sat;
		v = val;
		chroma = (v * s) / FullScale;
		// triangle over two sectors, peak of 256 at odd sector starts
		ramp = h % RampPeriod;
		if (ramp >= SectorSize) begin
			ramp = RampPeriod - ramp;
		end
		second = (ramp * chroma) / SectorSize;
		case (h / SectorSize)
			0: begin r = chroma; g = second; b = 0;      end
			1: begin r = second; g = chroma; b = 0;      end
			2: begin r = 0;      g = chroma; b = second; end
			3: begin r = 0;      g = second; b = chroma; end
			4: begin r = second; g = 0;      b = chroma; end
			default: begin r = chroma; g = 0; b = second; end
		endcase
		// white floor lifts every channel, nothing can pass val
		base = v - chroma;
		c.red   = rhcg_pkg::ChanW'(r + base);
		c.green = rhcg_pkg::ChanW'(g + base);
		c.blue  = rhcg_pkg::ChanW'(b + base);
		c.hue   = hue;
		return c;
	endfunction

	task automatic check_field(input string field, input logic [rhcg_pkg::HueW-1:0] want,
		input logic [rhcg_pkg::HueW-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			color_errors++;
		end
	endtask

	// both handshakes sampled at the rising edge; color checked before the
	// tick of the same edge is booked so a stray word cannot match it
	always @(posedge clk) begin
		color_word_t want;
		color_word_t predicted;
		if (arst_n && color_ch.valid && color_ch.ready) begin
			if (expected_colors.size() == 0) begin
				$error("color word with no tick waiting: hue %0d", color_ch.hue_out);
				color_errors++;
			end else begin
				want = expected_colors.pop_front();
				check_field("red", rhcg_pkg::HueW'(want.red), rhcg_pkg::HueW'(color_ch.red));
				check_field("green", rhcg_pkg::HueW'(want.green),
					rhcg_pkg::HueW'(color_ch.green));
				check_field("blue", rhcg_pkg::HueW'(want.blue), rhcg_pkg::HueW'(color_ch.blue));
				check_field("hue_out", want.hue, color_ch.hue_out);
			end
		end
		if (arst_n && tick_ch.valid && tick_ch.ready) begin
			predicted = predict_color(hue_now, sat_cfg, bright_cfg);
			expected_colors.push_back(use_known ? known_color : predicted);
			// hue moves on once the tick is booked, wraps at the ring
			if (tick_ch.advance) begin
				hue_now = rhcg_pkg::HueW'((int'(hue_now) + int'(step_cfg)) % RingSize);
			end
		end
	end

	// receiver: ready dropped at random, on IdlePct percent of cycles, unless in the calm stretch
	always @(negedge clk) begin
		color_ch.ready = calm_stretch || ($urandom_range(99) >= IdlePct);
	end

	// one register write, mirrored into the predictor; block is idle here
	task automatic write_reg(input logic [1:0] idx, input logic [rhcg_pkg::CfgW-1:0] data);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		case (idx)
			IdxStep:   step_cfg   = data;
			IdxSat:    sat_cfg    = data[rhcg_pkg::ChanW-1:0];
			IdxBright: bright_cfg = data[rhcg_pkg::ChanW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// offer one tick word, with random gaps ahead of it, until it is taken
	task automatic send_tick(input logic adv);
		while (!calm_stretch && $urandom_range(99) < IdlePct) begin
			tick_ch.valid   = 1'b0;
			tick_ch.advance = 1'($urandom_range(1));
			@(negedge clk);
		end
		tick_ch.valid   = 1'b1;
		tick_ch.advance = adv;
		@(posedge clk);
		while (!tick_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// hold off until every owed color word has come back
	task automatic wait_drained();
		tick_ch.valid = 1'b0;
		while (expected_colors.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		logic adv;
		logic [rhcg_pkg::CfgW-1:0] rnd;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = IdxStep;
		cfg_data        = '0;
		tick_ch.valid   = 1'b0;
		tick_ch.advance = 1'b0;
		color_ch.ready  = 1'b0;
		step_cfg        = 11'd19;
		sat_cfg         = 8'd255;
		bright_cfg      = 8'd8;
		hue_now         = '0;

		// reset colors, white, black, sector corners, step aliasing, spare index
		directed_rows = '{
			// reset settings, hue 0, with and without advance
			'{ROW_TICK,  1'b0, IdxStep,   11'd0,    1'b1, '{8'd8,   8'd0,   8'd0,   11'd0}},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd8,   8'd0,   8'd0,   11'd0}},
			'{ROW_TICK,  1'b0, IdxStep,   11'd0,    1'b0, '0},
			// zero saturation: every channel at value
			'{ROW_WRITE, 1'b0, IdxSat,    11'd0,    1'b0, '0},
			'{ROW_WRITE, 1'b0, IdxBright, 11'd255,  1'b0, '0},
			'{ROW_TICK,  1'b0, IdxStep,   11'd0,    1'b1, '{8'd255, 8'd255, 8'd255, 11'd19}},
			// upper data bits dropped on an 8-bit register; zero value is black
			'{ROW_WRITE, 1'b0, IdxSat,    11'd2047, 1'b0, '0},
			'{ROW_WRITE, 1'b0, IdxBright, 11'd0,    1'b0, '0},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   11'd19}},
			// full scale, then bring the hue back to 0
			'{ROW_WRITE, 1'b0, IdxBright, 11'd255,  1'b0, '0},
			'{ROW_WRITE, 1'b0, IdxStep,   11'd1498, 1'b0, '0},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b0, '0},
			// one sector per tick: the six corners of the ring
			'{ROW_WRITE, 1'b0, IdxStep,   11'd256,  1'b0, '0},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd255, 8'd0,   8'd0,   11'd0}},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd255, 8'd255, 8'd0,   11'd256}},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd0,   8'd255, 8'd0,   11'd512}},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd0,   8'd255, 8'd255, 11'd768}},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd0,   8'd0,   8'd255, 11'd1024}},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd255, 8'd0,   8'd255, 11'd1280}},
			// step past the ring acts as step - 1536
			'{ROW_WRITE, 1'b0, IdxStep,   11'd2047, 1'b0, '0},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b1, '{8'd255, 8'd0,   8'd0,   11'd0}},
			// write to the spare index must leave the step alone
			'{ROW_WRITE, 1'b0, IdxSpare,  11'd0,    1'b0, '0},
			'{ROW_TICK,  1'b1, IdxStep,   11'd0,    1'b0, '0},
			'{ROW_TICK,  1'b0, IdxStep,   11'd0,    1'b0, '0}
		};

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				use_known   = directed_rows[i].typed;
				known_color = directed_rows[i].known_color;
				send_tick(directed_rows[i].advance);
			end
		end
		use_known = 1'b0;

		// random words over a series of settings; each phase starts drained,
		// which also gives the sender's full pause
		for (int phase = 0; phase < PhaseCount; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					write_reg(IdxStep, 11'd0);
					write_reg(IdxSat, 11'd255);
					write_reg(IdxBright, 11'd255);
				end
				1: begin
					write_reg(IdxStep, 11'd1535);
					write_reg(IdxSat, 11'd0);
					write_reg(IdxBright, rhcg_pkg::CfgW'($urandom_range(255)));
				end
				2: begin
					write_reg(IdxStep, 11'd2047);
					write_reg(IdxSat, rhcg_pkg::CfgW'($urandom_range(255)));
					write_reg(IdxBright, 11'd0);
				end
				3: begin
					// fine walk at full scale
					write_reg(IdxStep, 11'd1);
					write_reg(IdxSat, 11'd255);
					write_reg(IdxBright, 11'd255);
				end
				default: begin
					rnd = rhcg_pkg::CfgW'($urandom_range(2047));
					write_reg(IdxSpare, rnd);
					write_reg(IdxStep, rhcg_pkg::CfgW'($urandom_range(2047)));
					write_reg(IdxSat, rhcg_pkg::CfgW'($urandom_range(2047)));
					write_reg(IdxBright, rhcg_pkg::CfgW'($urandom_range(2047)));
				end
			endcase
			calm_stretch = (phase == 4);
			for (int n = 0; n < PhaseWords; n++) begin
				adv = ($urandom_range(99) < 75);
				send_tick(adv);
			end
		end
		calm_stretch = 1'b0;

		wait_drained();
		repeat (DrainCycles) @(negedge clk);
		if (color_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// hang guard
	initial begin
		#(TimeLimit);
		$display("tb: failure");
		$finish;
	end

endmodule
